@@ rtl/wcr_pkg.sv @@
// Shared types and constants of the waveform column renderer.
// No dependencies; the divider and the top level refer to it by scoped names.
`default_nettype none

package wcr_pkg;

  // Field widths
  localparam int SMP_W   = 16;  // signed sample
  localparam int COORD_W = 10;  // screen row / column
  localparam int ROW_W   = 11;  // plot rows up to top + height
  localparam int HGT_W   = 6;   // plot height
  localparam int RGB_W   = 24;  // packed color
  localparam int CH_W    = 8;   // one color channel

  // Shared divider: magnitude of span*(sample-low) and of the data range
  localparam int DIV_W   = 22;
  localparam int DVS_W   = 16;
  localparam int STEP_W  = 5;
  localparam logic [STEP_W-1:0] ROW_STEPS = STEP_W'(DIV_W);
  localparam logic [STEP_W-1:0] CLR_STEPS = STEP_W'(CH_W);
  localparam int CLR_SHIFT = DIV_W - CH_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLOT_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLOT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLOT_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLOT_RIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_COLOR = 3'd6;

  // Register reset values
  localparam logic [SMP_W-1:0]   RST_DATA_LOW    = 16'd0;
  localparam logic [SMP_W-1:0]   RST_DATA_HIGH   = 16'd500;
  localparam logic [COORD_W-1:0] RST_PLOT_TOP    = 10'd0;
  localparam logic [HGT_W-1:0]   RST_PLOT_HEIGHT = 6'd63;
  localparam logic [COORD_W-1:0] RST_PLOT_LEFT   = 10'd0;
  localparam logic [COORD_W-1:0] RST_PLOT_RIGHT  = 10'd255;
  localparam logic [RGB_W-1:0]   RST_TRACE_COLOR = 24'hFF0000;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_max;
    logic signed [SMP_W-1:0] sample_min;
    logic signed [SMP_W-1:0] sample_mid;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [RGB_W-1:0]   pixel_color;
    logic               last_pixel;
  } out_item_t;

  // Divider command
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

endpackage

`default_nettype wire

@@ rtl/wcr_stream_if.sv @@
// Valid/ready channel carrying one payload item per transfer.
// Payload type comes from wcr_pkg at instantiation.
`default_nettype none

interface wcr_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/wcr_div.sv @@
// Shared restoring divider, one quotient bit per cycle, unsigned.
// Depends on wcr_pkg (widths, div_cmd_t).
`default_nettype none

module wcr_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire wcr_pkg::div_cmd_t        cmd,
  input  wire logic [wcr_pkg::DIV_W-1:0] dividend,
  input  wire logic [wcr_pkg::DVS_W-1:0] divisor,
  output logic                          done,
  output logic [wcr_pkg::DIV_W-1:0]     quot,
  output logic [wcr_pkg::DVS_W-1:0]     rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [wcr_pkg::DVS_W-1:0]     rem_r;
  logic [wcr_pkg::DIV_W-1:0]     quo_r;   // dividend shifts out, quotient shifts in
  logic [wcr_pkg::DVS_W-1:0]     dvs_r;
  logic [wcr_pkg::STEP_W-1:0]    cnt_r;

  logic [wcr_pkg::DVS_W:0]       trial;
  logic [wcr_pkg::DVS_W:0]       diff;
  logic                          qbit;
  logic [wcr_pkg::DVS_W-1:0]     rem_nxt;

  assign trial   = {rem_r, quo_r[wcr_pkg::DIV_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign qbit    = (trial >= {1'b0, dvs_r});
  assign rem_nxt = qbit ? diff[wcr_pkg::DVS_W-1:0] : trial[wcr_pkg::DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == wcr_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= cmd.steps;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[wcr_pkg::DIV_W-2:0], qbit};
      cnt_r <= cnt_r - wcr_pkg::STEP_W'(1);
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

@@ rtl/waveform_column_renderer.sv @@
// Top level of the waveform column renderer: config registers, sequencer, fade lanes.
// Depends on wcr_pkg, wcr_stream_if and wcr_div.
//
//   channel  | dir | payload                                   | transfer when
//   ---------+-----+-------------------------------------------+--------------------
//   in_ch    | in  | sample_max, sample_min, sample_mid        | valid && ready
//   out_ch   | out | pixel_x, pixel_y, pixel_color, last_pixel | valid && ready
//   cfg_*    | in  | cfg_index, cfg_data                       | cfg_we
//
// The single restoring divider sets the pace: each of the three rows takes a multiply,
// a divider start, a wait for the divider and a clamp. A line that spans rows adds setup
// and three channel divisions (c/n), then one fade step per index up to the farthest
// emitted pixel (at most 32 steps), and the idle state then takes the next column.
// in_ch.ready is high only between columns. Output stalls hold the sequencer on the
// pending pixel; the last pixel may still sit in the output register while the next
// column is taken. Reset is synchronous, active low; there is no clearing pass.
`default_nettype none

module waveform_column_renderer #(
  parameter int LINE_WIDTH = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  wcr_stream_if.sink                         in_ch,
  wcr_stream_if.source                       out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [wcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wcr_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,   // wait for a column
    S_MUL,    // span * (sample - data_low)
    S_RDIV,   // start row division
    S_RWAIT,
    S_ROW,    // subtract from base, clamp
    S_PREP,   // line length, fade divisor, last-pixel bounds
    S_CDIV,   // start channel / n division
    S_CWAIT,
    S_MID,    // mid pixel
    S_STEP,   // advance i, fade lanes
    S_LO,     // pixel at mid + i
    S_HI      // pixel at mid - i
  } state_t;

  localparam int SIGN_W = 24;  // width of signed row arithmetic

  // ---------------- configuration registers ----------------
  logic signed [wcr_pkg::SMP_W-1:0] data_low_r, data_high_r;
  logic [wcr_pkg::COORD_W-1:0]      plot_top_r, plot_left_r, plot_right_r;
  logic [wcr_pkg::HGT_W-1:0]        plot_height_r;
  logic [wcr_pkg::RGB_W-1:0]        trace_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_low_r    <= wcr_pkg::RST_DATA_LOW;
      data_high_r   <= wcr_pkg::RST_DATA_HIGH;
      plot_top_r    <= wcr_pkg::RST_PLOT_TOP;
      plot_height_r <= wcr_pkg::RST_PLOT_HEIGHT;
      plot_left_r   <= wcr_pkg::RST_PLOT_LEFT;
      plot_right_r  <= wcr_pkg::RST_PLOT_RIGHT;
      trace_color_r <= wcr_pkg::RST_TRACE_COLOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wcr_pkg::CFG_DATA_LOW:    data_low_r    <= cfg_data[wcr_pkg::SMP_W-1:0];
        wcr_pkg::CFG_DATA_HIGH:   data_high_r   <= cfg_data[wcr_pkg::SMP_W-1:0];
        wcr_pkg::CFG_PLOT_TOP:    plot_top_r    <= cfg_data[wcr_pkg::COORD_W-1:0];
        wcr_pkg::CFG_PLOT_HEIGHT: plot_height_r <= cfg_data[wcr_pkg::HGT_W-1:0];
        wcr_pkg::CFG_PLOT_LEFT:   plot_left_r   <= cfg_data[wcr_pkg::COORD_W-1:0];
        wcr_pkg::CFG_PLOT_RIGHT:  plot_right_r  <= cfg_data[wcr_pkg::COORD_W-1:0];
        wcr_pkg::CFG_TRACE_COLOR: trace_color_r <= cfg_data[wcr_pkg::RGB_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer registers ----------------
  state_t                             state_r;
  logic [1:0]                         k_r;        // row: 0 y_max, 1 y_min, 2 mid
  logic [1:0]                         ch_r;       // color lane: 0 red, 1 green, 2 blue
  logic [wcr_pkg::ROW_W-1:0]          cursor_r;   // column cursor
  logic signed [wcr_pkg::SMP_W-1:0]   smax_r, smin_r, smid_r;
  logic [wcr_pkg::DIV_W-1:0]          num_mag_r;
  logic                               qneg_r;
  logic [wcr_pkg::ROW_W-1:0]          ymax_r, ymin_r, mid_r;
  logic [wcr_pkg::HGT_W-1:0]          n_r, lim_r, ia_r, ib_r, i_r;
  logic [wcr_pkg::CH_W-1:0]           lq_r [3];   // faded channel value
  logic [wcr_pkg::HGT_W-1:0]          lr_r [3];   // remainder, below n
  logic [wcr_pkg::CH_W-1:0]           la_r [3];   // c / n
  logic [wcr_pkg::HGT_W-1:0]          lb_r [3];   // c % n

  logic                               out_valid_r;
  logic [wcr_pkg::COORD_W-1:0]        px_x_r, px_y_r;
  logic [wcr_pkg::RGB_W-1:0]          px_c_r;
  logic                               px_last_r;

  // ---------------- scaling datapath ----------------
  logic signed [wcr_pkg::SMP_W:0]     drange_w;
  logic [wcr_pkg::SMP_W:0]            drange_abs_w;
  logic [wcr_pkg::DVS_W-1:0]          div_mag_w;
  logic                               div_neg_w;
  logic signed [wcr_pkg::SMP_W-1:0]   smp_w;
  logic signed [wcr_pkg::SMP_W:0]     diff_w;
  logic signed [wcr_pkg::DIV_W:0]     prod_w;
  logic [wcr_pkg::DIV_W:0]            prod_abs_w;

  assign drange_w     = {data_high_r[wcr_pkg::SMP_W-1], data_high_r}
                      - {data_low_r[wcr_pkg::SMP_W-1], data_low_r};
  assign div_neg_w    = drange_w[wcr_pkg::SMP_W];
  assign drange_abs_w = div_neg_w ? (-drange_w) : drange_w;
  // equal data bounds: divide by one
  assign div_mag_w    = (drange_w == '0) ? wcr_pkg::DVS_W'(1)
                                         : drange_abs_w[wcr_pkg::DVS_W-1:0];

  always_comb begin
    case (k_r)
      2'd0:    smp_w = smin_r;
      2'd1:    smp_w = smax_r;
      default: smp_w = smid_r;
    endcase
  end

  assign diff_w     = {smp_w[wcr_pkg::SMP_W-1], smp_w}
                    - {data_low_r[wcr_pkg::SMP_W-1], data_low_r};
  assign prod_w     = $signed({1'b0, plot_height_r}) * diff_w;
  assign prod_abs_w = prod_w[wcr_pkg::DIV_W] ? (-prod_w) : prod_w;

  // ---------------- shared divider ----------------
  wcr_pkg::div_cmd_t                  div_cmd_w;
  logic [wcr_pkg::DIV_W-1:0]          div_a_w;
  logic [wcr_pkg::DVS_W-1:0]          div_b_w;
  logic                               div_done_w;
  logic [wcr_pkg::DIV_W-1:0]          quot_w;
  logic [wcr_pkg::DVS_W-1:0]          rem_w;
  logic [wcr_pkg::CH_W-1:0]           chan_w;

  always_comb begin
    case (ch_r)
      2'd0:    chan_w = trace_color_r[23:16];
      2'd1:    chan_w = trace_color_r[15:8];
      default: chan_w = trace_color_r[7:0];
    endcase
  end

  always_comb begin
    div_cmd_w.start = (state_r == S_RDIV) || (state_r == S_CDIV);
    if (state_r == S_CDIV) begin
      div_cmd_w.steps = wcr_pkg::CLR_STEPS;
      div_a_w         = {chan_w, wcr_pkg::CLR_SHIFT'(0)};
      div_b_w         = wcr_pkg::DVS_W'(n_r);
    end else begin
      div_cmd_w.steps = wcr_pkg::ROW_STEPS;
      div_a_w         = num_mag_r;
      div_b_w         = div_mag_w;
    end
  end

  wcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd_w),
    .dividend (div_a_w),
    .divisor  (div_b_w),
    .done     (div_done_w),
    .quot     (quot_w),
    .rem      (rem_w)
  );

  // ---------------- row: base - quotient, clamped ----------------
  logic [wcr_pkg::ROW_W-1:0]          bottom_w;
  logic signed [SIGN_W-1:0]           base_w, qs_w, yv_w;
  logic [wcr_pkg::ROW_W-1:0]          yclamp_w;

  assign bottom_w = wcr_pkg::ROW_W'(plot_top_r) + wcr_pkg::ROW_W'(plot_height_r);

  always_comb begin
    case (k_r)
      2'd0:    base_w = $signed(SIGN_W'(bottom_w)) + SIGN_W'(LINE_WIDTH);
      2'd1:    base_w = $signed(SIGN_W'(bottom_w)) - SIGN_W'(LINE_WIDTH);
      default: base_w = $signed(SIGN_W'(bottom_w));
    endcase
  end

  assign qs_w = qneg_r ? -$signed(SIGN_W'(quot_w)) : $signed(SIGN_W'(quot_w));
  assign yv_w = base_w - qs_w;

  always_comb begin
    if (yv_w > $signed(SIGN_W'(bottom_w)))        yclamp_w = bottom_w;
    else if (yv_w < $signed(SIGN_W'(plot_top_r))) yclamp_w = wcr_pkg::ROW_W'(plot_top_r);
    else                                          yclamp_w = yv_w[wcr_pkg::ROW_W-1:0];
  end

  // ---------------- line setup ----------------
  logic signed [wcr_pkg::ROW_W:0]     dy_w, db_w, da_w;
  logic [wcr_pkg::HGT_W-1:0]          half_w, lim_w, ia_w, ib_w;

  // rows are clamped to the plot, so |dy| <= 63
  assign dy_w   = $signed({1'b0, ymax_r}) - $signed({1'b0, ymin_r});
  assign db_w   = $signed({1'b0, ymax_r}) - $signed({1'b0, mid_r});
  assign da_w   = $signed({1'b0, mid_r}) - $signed({1'b0, ymin_r});
  assign half_w = {1'b0, dy_w[wcr_pkg::HGT_W-1:1]};
  assign lim_w  = half_w + wcr_pkg::HGT_W'(1);

  // last i on each side that lands inside [y_min, y_max]
  always_comb begin
    if (dy_w < 1 || db_w < 1)                    ib_w = '0;
    else if (db_w > $signed((wcr_pkg::ROW_W+1)'(lim_w))) ib_w = lim_w;
    else                                         ib_w = db_w[wcr_pkg::HGT_W-1:0];
    if (dy_w < 1 || da_w < 1)                    ia_w = '0;
    else if (da_w > $signed((wcr_pkg::ROW_W+1)'(lim_w))) ia_w = lim_w;
    else                                         ia_w = da_w[wcr_pkg::HGT_W-1:0];
  end

  // ---------------- fade lanes: c*(n-i)/n kept as quotient/remainder ----------------
  logic [wcr_pkg::CH_W-1:0]           lq_nxt [3];
  logic [wcr_pkg::HGT_W-1:0]          lr_nxt [3];
  logic signed [wcr_pkg::HGT_W+1:0]   lt_w   [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lt_w[l] = $signed({2'b0, lr_r[l]}) - $signed({2'b0, lb_r[l]});
      if (lt_w[l] < 0) begin
        lr_nxt[l] = lr_r[l] + n_r - lb_r[l];
        lq_nxt[l] = lq_r[l] - la_r[l] - wcr_pkg::CH_W'(1);
      end else begin
        lr_nxt[l] = lt_w[l][wcr_pkg::HGT_W-1:0];
        lq_nxt[l] = lq_r[l] - la_r[l];
      end
    end
  end

  // ---------------- pixel slot ----------------
  logic                               emit_w, last_w, out_free_w, load_px_w;
  logic [wcr_pkg::ROW_W-1:0]          row_w;
  logic [wcr_pkg::RGB_W-1:0]          color_w;

  always_comb begin
    emit_w  = 1'b0;
    last_w  = 1'b0;
    row_w   = mid_r;
    color_w = {lq_r[0], lq_r[1], lq_r[2]};
    case (state_r)
      S_MID: begin
        emit_w  = 1'b1;
        last_w  = (ia_r == '0) && (ib_r == '0);
        color_w = trace_color_r;
      end
      S_LO: begin
        emit_w = (i_r <= ib_r);
        last_w = (i_r == ib_r) && (ia_r < ib_r);
        row_w  = mid_r + wcr_pkg::ROW_W'(i_r);
      end
      S_HI: begin
        emit_w = (i_r <= ia_r);
        last_w = (i_r == ia_r) && (ia_r >= ib_r);
        row_w  = mid_r - wcr_pkg::ROW_W'(i_r);
      end
      default: ;
    endcase
  end

  assign out_free_w = !out_valid_r || out_ch.ready;
  assign load_px_w  = emit_w && out_free_w;

  // ---------------- sequencer ----------------
  logic in_xfer_w;
  assign in_xfer_w = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cursor_r    <= wcr_pkg::ROW_W'(wcr_pkg::RST_PLOT_LEFT);
    end else begin
      if (load_px_w)         out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (load_px_w) begin
        px_x_r    <= cursor_r[wcr_pkg::COORD_W-1:0];
        px_y_r    <= row_w[wcr_pkg::COORD_W-1:0];
        px_c_r    <= color_w;
        px_last_r <= last_w;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer_w) begin
            // wrap before drawing
            if (cursor_r > wcr_pkg::ROW_W'(plot_right_r))
              cursor_r <= wcr_pkg::ROW_W'(plot_left_r);
            state_r <= S_MUL;
          end
        end
        S_MUL:   state_r <= S_RDIV;
        S_RDIV:  state_r <= S_RWAIT;
        S_RWAIT: if (div_done_w) state_r <= S_ROW;
        S_ROW:   state_r <= (k_r == 2'd2) ? S_PREP : S_MUL;
        S_PREP:  state_r <= (dy_w < 1) ? S_MID : S_CDIV;
        S_CDIV:  state_r <= S_CWAIT;
        S_CWAIT: if (div_done_w) state_r <= (ch_r == 2'd2) ? S_MID : S_CDIV;
        S_STEP:  state_r <= S_LO;
        S_MID, S_LO, S_HI: begin
          if (!emit_w || out_free_w) begin
            if (emit_w && last_w) begin
              cursor_r <= cursor_r + wcr_pkg::ROW_W'(1);
              state_r  <= S_IDLE;
            end else begin
              state_r <= (state_r == S_LO) ? S_HI : S_STEP;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        smax_r <= in_ch.payload.sample_max;
        smin_r <= in_ch.payload.sample_min;
        smid_r <= in_ch.payload.sample_mid;
        k_r    <= 2'd0;
      end
      S_MUL: begin
        num_mag_r <= prod_abs_w[wcr_pkg::DIV_W-1:0];
        qneg_r    <= prod_w[wcr_pkg::DIV_W] ^ div_neg_w;
      end
      S_ROW: begin
        case (k_r)
          2'd0:    ymax_r <= yclamp_w;
          2'd1:    ymin_r <= yclamp_w;
          default: mid_r  <= yclamp_w;
        endcase
        k_r <= k_r + 2'd1;
      end
      S_PREP: begin
        n_r   <= half_w + wcr_pkg::HGT_W'(2);
        lim_r <= lim_w;
        ia_r  <= ia_w;
        ib_r  <= ib_w;
        i_r   <= '0;
        ch_r  <= 2'd0;
      end
      S_CWAIT: begin
        if (div_done_w) begin
          la_r[ch_r] <= quot_w[wcr_pkg::CH_W-1:0];
          lb_r[ch_r] <= rem_w[wcr_pkg::HGT_W-1:0];
          lq_r[ch_r] <= chan_w;
          lr_r[ch_r] <= '0;
          ch_r       <= ch_r + 2'd1;
        end
      end
      S_STEP: begin
        i_r <= i_r + wcr_pkg::HGT_W'(1);
        for (int l = 0; l < 3; l++) begin
          lq_r[l] <= lq_nxt[l];
          lr_r[l] <= lr_nxt[l];
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready                = (state_r == S_IDLE);
  assign out_ch.valid               = out_valid_r;
  assign out_ch.payload.pixel_x     = px_x_r;
  assign out_ch.payload.pixel_y     = px_y_r;
  assign out_ch.payload.pixel_color = px_c_r;
  assign out_ch.payload.last_pixel  = px_last_r;

  // ---------------- assertions ----------------
  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done_w |-> (state_r == S_RWAIT) || (state_r == S_CWAIT))
    else $error("divider finished outside a wait state");

  // a taken column closes the input until its last pixel has been loaded
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer_w |=> !in_ch.ready)
    else $error("input still open after a column transfer");

  // faded pixels never pass the far end of the line on their own side
  assert property (@(posedge clk) disable iff (!rst_n)
    load_px_w |-> ((state_r != S_LO) || (row_w <= ymax_r)) &&
                  ((state_r != S_HI) || (row_w >= ymin_r)))
    else $error("faded pixel past the line end");

  // fade index stays inside 1 .. (dy>>1)+1
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LO) |-> (i_r >= wcr_pkg::HGT_W'(1)) && (i_r <= lim_r))
    else $error("fade index out of range");

endmodule

`default_nettype wire
